>>> sv/evad_pkg.sv
// Shared widths, register codes and reset values for the voice activity detector.
`default_nettype none
package evad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int SUM_W    = 40;
  localparam int RMS_W    = 16;
  localparam int CONF_W   = 8;
  localparam int THR_W    = 15;
  localparam int MS_W     = 16;
  localparam int CFG_W    = 16;

  // register map
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TRIGGER   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COOLDOWN  = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET  = 15'd800;
  localparam logic [MS_W-1:0]  TRIG_RESET = 16'd500;
  localparam logic [MS_W-1:0]  COOL_RESET = 16'd3000;

  // serial squarer: one multiplier bit per cycle
  localparam int MUL_CNT_W = $clog2(SAMPLE_W);

  // shared restoring divider
  localparam int DIV_DW    = SUM_W;
  localparam int DIV_VW    = THR_W + 2;
  localparam int DIV_CNT_W = $clog2(DIV_DW);

  // digit-by-digit square root, two radicand bits per cycle
  localparam int SQRT_W     = 32;
  localparam int SQRT_STEPS = SQRT_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  localparam logic [CONF_W-1:0] CONF_MAX = 8'd255;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [TIME_W-1:0]          time_ms_t;
  typedef logic [RMS_W-1:0]           rms_t;
  typedef logic [CONF_W-1:0]          conf_t;

endpackage
`default_nettype wire

>>> sv/evad_ifs.sv
// Valid/ready channel interfaces for samples in and frame results out.
`default_nettype none
interface evad_in_if import evad_pkg::*; ();
  logic     valid;
  logic     ready;
  sample_t  sample;
  logic     frame_last;
  time_ms_t time_ms;
  logic     listening;

  modport source (output valid, sample, frame_last, time_ms, listening, input ready);
  modport sink   (input valid, sample, frame_last, time_ms, listening, output ready);
endinterface

interface evad_out_if import evad_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  detected;
  conf_t confidence;
  rms_t  frame_rms;
  logic  in_cooldown;

  modport source (output valid, detected, confidence, frame_rms, in_cooldown, input ready);
  modport sink   (input valid, detected, confidence, frame_rms, in_cooldown, output ready);
endinterface
`default_nettype wire

>>> sv/energy_voice_activity_detector.sv
// Energy based voice activity detector: frame energy, RMS, sustain and cooldown logic.
//
// Usage notes:
//  - samples: valid/ready channel of PCM samples. frame_last marks the frame's
//    last sample, whose time_ms stamps the frame. listening low drops the
//    sample and clears the frame and the sustain period; nothing is emitted.
//  - results: one transfer per frame end while listening: detected,
//    confidence, frame_rms, in_cooldown.
//  - wr_en/wr_index/wr_data: register writes (0 threshold, 1 trigger ms,
//    2 cooldown ms), only while the block is idle.
//  - Sequence: an ordinary sample is squared one multiplier bit per cycle
//    after the accept cycle. A frame end adds the cooldown check, the mean
//    division, the square root, the confidence division on a detecting
//    frame, and the output load. A cooldown frame skips the divisions and
//    the square root. No new sample is taken until the block is idle again.
//  - Reset (synchronous, rst high) restores register defaults, clears the
//    frame, the sustain and detection history and empties the output.
//  - Stall: the result waits in the output register; further samples are
//    still taken until the next frame end, which then holds until the
//    waiting result is transferred.
`default_nettype none
module energy_voice_activity_detector import evad_pkg::*; #(
  parameter int FRAME_SAMPLES = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  evad_in_if.sink              samples,
  evad_out_if.source           results
);

  localparam int CNT_W = $clog2(FRAME_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_SAMPLES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_FEND = 3'd2;
  localparam logic [2:0] ST_DIVM = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DIVC = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0] state;

  // configuration
  logic [THR_W-1:0] threshold;
  logic [MS_W-1:0]  trigger;
  logic [MS_W-1:0]  cooldown;

  // detector state
  logic [SUM_W-1:0] square_sum;
  logic [CNT_W-1:0] frame_count;
  logic             sustain_valid;
  time_ms_t         sustain_start;
  logic             detect_valid;
  time_ms_t         last_detect;

  // per-sample working registers
  logic                 frame_end;
  time_ms_t             now;
  logic [2*SAMPLE_W-1:0] mcand;
  logic [SAMPLE_W-1:0]  mplier;
  logic [MUL_CNT_W-1:0] mul_cnt;
  logic [SAMPLE_W-1:0]  mag;

  // result staging and output register
  logic  res_det;
  conf_t res_conf;
  rms_t  res_rms;
  logic  res_cool;
  logic  out_valid;
  logic  out_load;

  // shared units
  logic              div_start;
  logic [DIV_DW-1:0] div_a;
  logic [DIV_VW-1:0] div_b;
  logic [DIV_DW-1:0] div_quot;
  logic              div_done;
  logic              sqrt_start;
  rms_t              sqrt_root;
  logic              sqrt_done;

  logic                 accept;
  logic                 cool_hit;
  logic                 voiced;
  logic                 elapsed;
  logic [RMS_W+7:0]     rms255;
  logic [DIV_VW-1:0]    thr3;
  conf_t                conf_sat;

  assign accept    = samples.valid && samples.ready;
  // no transfer while reset is held
  assign samples.ready = (state == ST_IDLE) && !rst;

  // two's complement magnitude; -32768 maps to 0x8000
  assign mag = samples.sample[SAMPLE_W-1] ? SAMPLE_W'(-samples.sample)
                                          : SAMPLE_W'(samples.sample);

  assign cool_hit = detect_valid && ((now - last_detect) < TIME_W'(cooldown));
  assign voiced   = sqrt_root > RMS_W'(threshold);
  assign elapsed  = (now - sustain_start) >= TIME_W'(trigger);
  assign rms255   = {sqrt_root, 8'd0} - {8'd0, sqrt_root};
  assign thr3     = {1'b0, threshold, 1'b0} + {2'b00, threshold};
  assign conf_sat = (|div_quot[DIV_DW-1:CONF_W]) ? CONF_MAX : div_quot[CONF_W-1:0];
  assign out_load = (state == ST_EMIT) && (!out_valid || results.ready);

  // divider serves both the frame mean and the confidence ratio
  always_comb begin
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    div_a      = square_sum;
    div_b      = DIV_VW'(frame_count);
    unique case (state)
      ST_FEND: begin
        div_start = !cool_hit;
      end
      ST_DIVM: begin
        sqrt_start = div_done;
      end
      ST_SQRT: begin
        if (sqrt_done && voiced && sustain_valid && elapsed && (threshold != '0)) begin
          div_start = 1'b1;
          div_a     = DIV_DW'(rms255);
          div_b     = thr3;
        end
      end
      default: begin
      end
    endcase
  end

  evad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_quot),
    .done     (div_done)
  );

  // mean never exceeds 2^30, so the low word carries it whole
  evad_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (div_quot[SQRT_W-1:0]),
    .root     (sqrt_root),
    .done     (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
      trigger   <= TRIG_RESET;
      cooldown  <= COOL_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_THRESHOLD: threshold <= wr_data[THR_W-1:0];
        REG_TRIGGER:   trigger   <= wr_data[MS_W-1:0];
        REG_COOLDOWN:  cooldown  <= wr_data[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      square_sum    <= '0;
      frame_count   <= '0;
      sustain_valid <= 1'b0;
      sustain_start <= '0;
      detect_valid  <= 1'b0;
      last_detect   <= '0;
      frame_end     <= 1'b0;
      now           <= '0;
      mcand         <= '0;
      mplier        <= '0;
      mul_cnt       <= '0;
      res_det       <= 1'b0;
      res_conf      <= '0;
      res_rms       <= '0;
      res_cool      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!samples.listening) begin
              square_sum    <= '0;
              frame_count   <= '0;
              sustain_valid <= 1'b0;
            end else begin
              frame_end <= samples.frame_last;
              now       <= samples.time_ms;
              if (frame_count < CNT_FULL) begin
                frame_count <= frame_count + 1'b1;
                mcand       <= (2*SAMPLE_W)'(mag);
                mplier      <= mag;
                mul_cnt     <= '0;
                state       <= ST_MUL;
              end else if (samples.frame_last) begin
                // full frame: sample ignored, its mark still ends the frame
                state <= ST_FEND;
              end
            end
          end
        end
        ST_MUL: begin
          // shift-add squaring straight into the frame sum
          if (mplier[0]) begin
            square_sum <= square_sum + SUM_W'(mcand);
          end
          mcand   <= mcand << 1;
          mplier  <= mplier >> 1;
          mul_cnt <= mul_cnt + 1'b1;
          if (mul_cnt == MUL_CNT_W'(SAMPLE_W - 1)) begin
            state <= frame_end ? ST_FEND : ST_IDLE;
          end
        end
        ST_FEND: begin
          // divider latches the sum this cycle unless in cooldown, so the frame can clear now
          square_sum  <= '0;
          frame_count <= '0;
          if (cool_hit) begin
            sustain_valid <= 1'b0;
            res_det       <= 1'b0;
            res_conf      <= '0;
            res_rms       <= '0;
            res_cool      <= 1'b1;
            state         <= ST_EMIT;
          end else begin
            state <= ST_DIVM;
          end
        end
        ST_DIVM: begin
          if (div_done) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            res_rms  <= sqrt_root;
            res_cool <= 1'b0;
            res_det  <= 1'b0;
            res_conf <= '0;
            state    <= ST_EMIT;
            if (voiced) begin
              if (!sustain_valid) begin
                // first voiced frame only opens the sustain period
                sustain_valid <= 1'b1;
                sustain_start <= now;
              end else if (elapsed) begin
                res_det       <= 1'b1;
                detect_valid  <= 1'b1;
                last_detect   <= now;
                sustain_valid <= 1'b0;
                if (threshold == '0) begin
                  res_conf <= CONF_MAX;
                end else begin
                  state <= ST_DIVC;
                end
              end
            end else begin
              sustain_valid <= 1'b0;
            end
          end
        end
        ST_DIVC: begin
          if (div_done) begin
            res_conf <= conf_sat;
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register: holds a result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid           <= 1'b0;
      results.detected    <= 1'b0;
      results.confidence  <= '0;
      results.frame_rms   <= '0;
      results.in_cooldown <= 1'b0;
    end else if (out_load) begin
      out_valid           <= 1'b1;
      results.detected    <= res_det;
      results.confidence  <= res_conf;
      results.frame_rms   <= res_rms;
      results.in_cooldown <= res_cool;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid = out_valid;

`ifndef SYNTHESIS
  a_cool_blank : assert property (@(posedge clk) disable iff (rst)
    results.valid && results.in_cooldown |->
      !results.detected && (results.frame_rms == '0) && (results.confidence == '0))
    else $error("cooldown result carries detection data");

  a_count_cap : assert property (@(posedge clk) disable iff (rst)
    frame_count <= CNT_FULL)
    else $error("frame count beyond capacity");

  a_detect_clears : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) && sqrt_done && voiced && sustain_valid && elapsed |=>
      detect_valid && !sustain_valid)
    else $error("detection did not record history");

  a_out_from_emit : assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == ST_EMIT)
    else $error("result loaded outside emit state");
`endif

endmodule
`default_nettype wire

>>> sv/evad_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module evad_div import evad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  output logic [DIV_DW-1:0] quotient,
  output logic              done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_VW-1:0]    rem;
  logic [DIV_VW-1:0]    dvs;
  logic [DIV_DW-1:0]    quo;
  logic [DIV_VW:0]      trial;
  logic [DIV_VW:0]      diff;

  assign trial    = {rem, quo[DIV_DW-1]};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      dvs  <= '0;
      quo  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        // diff sign bit set means trial < divisor
        if (!diff[DIV_VW]) begin
          rem <= diff[DIV_VW-1:0];
        end else begin
          rem <= trial[DIV_VW-1:0];
        end
        quo <= {quo[DIV_DW-2:0], ~diff[DIV_VW]};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/evad_sqrt.sv
// Integer square root, one root bit per cycle.
`default_nettype none
module evad_sqrt import evad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQRT_W-1:0] radicand,
  output rms_t              root,
  output logic              done
);

  logic                  busy;
  logic [SQRT_CNT_W-1:0] cnt;
  logic [SQRT_W-1:0]     v;
  logic [SQRT_W-1:0]     res;
  logic [SQRT_W-1:0]     bitm;
  logic [SQRT_W-1:0]     trial;

  assign trial = res + bitm;
  assign root  = res[RMS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      v    <= '0;
      res  <= '0;
      bitm <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v    <= radicand;
        res  <= '0;
        bitm <= SQRT_W'(1) << (SQRT_W - 2);
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
